// ===== hw/rtl/lbsa_pkg.sv =====
package lbsa_pkg;

  localparam int unsigned IdW    = 12;
  localparam int unsigned StampW = 32;

  // running search state that walks down the cell row
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              free;
    logic              min_vld;
    logic [IdW-1:0]    min_owner;
    logic [StampW-1:0] min_stamp;
  } carry_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IdW-1:0]    owner;
    logic [StampW-1:0] stamp;
  } wr_t;

endpackage

// ===== hw/rtl/lbsa_cell.sv =====
module lbsa_cell import lbsa_pkg::*; #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IdW-1:0]    id_i,
  input  carry_t            carry_i,
  input  logic [IdxW-1:0]   hit_idx_i,
  input  logic [IdxW-1:0]   free_idx_i,
  input  logic [IdxW-1:0]   min_idx_i,
  output carry_t            carry_o,
  output logic [IdxW-1:0]   hit_idx_o,
  output logic [IdxW-1:0]   free_idx_o,
  output logic [IdxW-1:0]   min_idx_o,
  input  wr_t               wr_i,
  input  logic [IdxW-1:0]   wr_idx_i
);

  logic [IdW-1:0]    owner_q;
  logic [StampW-1:0] stamp_q;
  carry_t            carry_d, carry_q;
  logic [IdxW-1:0]   hit_idx_d, hit_idx_q;
  logic [IdxW-1:0]   free_idx_d, free_idx_q;
  logic [IdxW-1:0]   min_idx_d, min_idx_q;

  always_comb begin
    carry_d    = carry_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    min_idx_d  = min_idx_i;
    if (!carry_i.hit && owner_q == id_i) begin
      carry_d.hit = 1'b1;
      hit_idx_d   = IdxW'(Idx);
    end
    // first free slot from the low end wins
    if (!carry_i.free && owner_q == '0) begin
      carry_d.free = 1'b1;
      free_idx_d   = IdxW'(Idx);
    end
    // strict compare keeps the lowest index on ties
    if (!carry_i.min_vld || stamp_q < carry_i.min_stamp) begin
      carry_d.min_vld   = 1'b1;
      carry_d.min_stamp = stamp_q;
      carry_d.min_owner = owner_q;
      min_idx_d         = IdxW'(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q    <= '0;
      stamp_q    <= '0;
      carry_q    <= '0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      min_idx_q  <= '0;
    end else begin
      carry_q    <= carry_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
      min_idx_q  <= min_idx_d;
      if (wr_i.en && wr_idx_i == IdxW'(Idx)) begin
        owner_q <= wr_i.owner;
        stamp_q <= wr_i.stamp;
      end
    end
  end

  assign carry_o    = carry_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign min_idx_o  = min_idx_q;

endmodule

// ===== hw/rtl/lru_binding_slot_allocator.sv =====
// channel   dir  tdata                                   tuser
// s_axis    in   [11:0] object_id                        [0] operation
// m_axis    out  [3:0] slot, [4] already_bound,          -
//                [5] evicted, [17:6] evicted_id, [18] found
//
// one request at a time: the search walks the slot row one cell per cycle,
// and the request then moves from scan to commit; a request with an id of
// zero skips the scan and goes straight to commit.
// reset clears all slots (free, stamp zero) and the use counter at once.
// a held result blocks the slot update until m_axis_tready, a new request
// is taken while the previous result still waits.
module lru_binding_slot_allocator import lbsa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] object_id
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [3:0] slot, [4] already_bound, [5] evicted,
                                      // [17:6] evicted_id, [18] found
);

  localparam int unsigned IdxW  = $clog2(NUM_SLOTS);
  localparam int unsigned SlotW = 4;

  typedef enum logic {
    OP_BIND   = 1'b0,
    OP_UNBIND = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic             found;
    logic [IdW-1:0]   evicted_id;
    logic             evicted;
    logic             already_bound;
    logic [SlotW-1:0] slot;
  } result_t;

  state_e            state_q;
  op_e               op_q;
  logic [IdW-1:0]    id_q;
  logic              ign_q;
  logic              start_q;
  logic [StampW-1:0] cnt_q;
  logic [StampW-1:0] cnt_inc;
  carry_t            fin_q;
  logic [IdxW-1:0]   fin_hit_idx_q, fin_free_idx_q, fin_min_idx_q;
  logic              out_vld_q;
  result_t           out_q;
  result_t           res_d;
  logic              commit;
  wr_t               wr_d, wr;
  logic [IdxW-1:0]   wr_idx;
  logic [IdW-1:0]    in_id;

  carry_t            carry    [NUM_SLOTS+1];
  logic [IdxW-1:0]   hit_idx  [NUM_SLOTS+1];
  logic [IdxW-1:0]   free_idx [NUM_SLOTS+1];
  logic [IdxW-1:0]   min_idx  [NUM_SLOTS+1];

  assign in_id = s_axis_tdata[IdW-1:0];

  always_comb begin
    carry[0]     = '0;
    carry[0].vld = start_q;
  end
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;
  assign min_idx[0]  = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    lbsa_cell #(
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .id_i       (id_q),
      .carry_i    (carry[g]),
      .hit_idx_i  (hit_idx[g]),
      .free_idx_i (free_idx[g]),
      .min_idx_i  (min_idx[g]),
      .carry_o    (carry[g+1]),
      .hit_idx_o  (hit_idx[g+1]),
      .free_idx_o (free_idx[g+1]),
      .min_idx_o  (min_idx[g+1]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx)
    );
  end

  assign cnt_inc = cnt_q + 1'b1;
  assign commit  = (state_q == ST_COMMIT) && (!out_vld_q || m_axis_tready);

  always_comb begin
    wr_d   = '0;
    wr_idx = '0;
    res_d  = '0;
    if (!ign_q) begin
      unique case (op_q)
        OP_UNBIND: begin
          if (fin_q.hit) begin
            wr_d.en     = 1'b1;
            wr_idx      = fin_hit_idx_q;
            res_d.slot  = SlotW'(fin_hit_idx_q);
            res_d.found = 1'b1;
          end
        end
        OP_BIND: begin
          wr_d.en    = 1'b1;
          wr_d.owner = id_q;
          wr_d.stamp = cnt_inc;
          priority if (fin_q.hit) begin
            wr_idx              = fin_hit_idx_q;
            res_d.slot          = SlotW'(fin_hit_idx_q);
            res_d.already_bound = 1'b1;
          end else if (fin_q.free) begin
            wr_idx     = fin_free_idx_q;
            res_d.slot = SlotW'(fin_free_idx_q);
          end else begin
            // all slots taken: replace the oldest one
            wr_idx           = fin_min_idx_q;
            res_d.slot       = SlotW'(fin_min_idx_q);
            res_d.evicted    = 1'b1;
            res_d.evicted_id = fin_q.min_owner;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    wr    = wr_d;
    wr.en = wr_d.en && commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      op_q           <= OP_BIND;
      id_q           <= '0;
      ign_q          <= 1'b0;
      start_q        <= 1'b0;
      cnt_q          <= '0;
      fin_q          <= '0;
      fin_hit_idx_q  <= '0;
      fin_free_idx_q <= '0;
      fin_min_idx_q  <= '0;
      out_vld_q      <= 1'b0;
      out_q          <= '0;
    end else begin
      start_q <= (state_q == ST_IDLE) && s_axis_tvalid && (in_id != '0);
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q <= op_e'(s_axis_tuser);
            id_q <= in_id;
            // a 12-bit id is always in range, only zero is ignored
            if (in_id == '0) begin
              ign_q   <= 1'b1;
              state_q <= ST_COMMIT;
            end else begin
              ign_q   <= 1'b0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (carry[NUM_SLOTS].vld) begin
            fin_q          <= carry[NUM_SLOTS];
            fin_hit_idx_q  <= hit_idx[NUM_SLOTS];
            fin_free_idx_q <= free_idx[NUM_SLOTS];
            fin_min_idx_q  <= min_idx[NUM_SLOTS];
            state_q        <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit) begin
            out_q <= res_d;
            if (!ign_q && op_q == OP_BIND) begin
              cnt_q <= cnt_inc;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q};

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbsa_pkg::*;

  localparam int unsigned NumSlots      = 16;
  localparam int unsigned IdRange       = 1 << IdW;
  localparam int unsigned RandomReqs    = 1830;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = NumSlots + 8;
  localparam int unsigned MaxPrinted    = 40;

  typedef enum logic {
    OP_BIND   = 1'b0,
    OP_UNBIND = 1'b1
  } op_e;

  typedef struct {
    op_e            op;
    logic [IdW-1:0] id;
  } bind_req_t;

  // m_axis_tdata layout, msb first
  typedef struct packed {
    logic [4:0]     pad;
    logic           found;
    logic [IdW-1:0] evicted_id;
    logic           evicted;
    logic           already_bound;
    logic [3:0]     slot;
  } slot_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  lru_binding_slot_allocator #(
    .NUM_SLOTS(NumSlots)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial forever #5 clk_i = ~clk_i;

  bind_req_t    bind_req_q[$];
  slot_result_t slot_results_q[$];

  // shadow of the slot table
  logic [IdW-1:0] slot_owner_q[NumSlots];
  logic [31:0]    slot_stamp_q[NumSlots];
  bit             id_bound_q[IdRange];
  logic [3:0]     id_slot_q[IdRange];
  logic [31:0]    use_count_q;

  int unsigned err_cnt;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_fills, n_hits, n_evictions, n_freed, n_unbind_miss, n_ignored;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (err_cnt < MaxPrinted) begin
      $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
    err_cnt++;
  endtask

  function automatic slot_result_t allocate_slot(input op_e op, input logic [IdW-1:0] id);
    slot_result_t res;
    int pick;
    int i;
    res  = '0;
    pick = -1;
    if (id == '0) begin
      n_ignored++;
      return res;
    end
    if (op == OP_UNBIND) begin
      if (id_bound_q[id]) begin
        pick               = id_slot_q[id];
        slot_owner_q[pick] = '0;
        slot_stamp_q[pick] = '0;
        id_bound_q[id]     = 1'b0;
        res.slot           = pick[3:0];
        res.found          = 1'b1;
        n_freed++;
      end else begin
        n_unbind_miss++;
      end
      return res;
    end
    use_count_q = use_count_q + 32'd1;
    if (id_bound_q[id]) begin
      slot_stamp_q[id_slot_q[id]] = use_count_q;
      res.slot                    = id_slot_q[id];
      res.already_bound           = 1'b1;
      n_hits++;
      return res;
    end
    for (i = 0; i < NumSlots; i++) begin
      if (pick < 0 && slot_owner_q[i] == '0) pick = i;
    end
    if (pick >= 0) begin
      n_fills++;
    end else begin
      // table full: oldest stamp goes, lowest index on a tie
      pick = 0;
      for (i = 1; i < NumSlots; i++) begin
        if (slot_stamp_q[i] < slot_stamp_q[pick]) pick = i;
      end
      res.evicted                    = 1'b1;
      res.evicted_id                 = slot_owner_q[pick];
      id_bound_q[slot_owner_q[pick]] = 1'b0;
      n_evictions++;
    end
    slot_owner_q[pick] = id;
    slot_stamp_q[pick] = use_count_q;
    id_bound_q[id]     = 1'b1;
    id_slot_q[id]      = pick[3:0];
    res.slot           = pick[3:0];
    return res;
  endfunction

  task automatic check_result(input slot_result_t got);
    slot_result_t want;
    if (slot_results_q.size() == 0) begin
      report_mismatch("result with no request pending", 0, got);
      return;
    end
    want = slot_results_q.pop_front();
    n_checked++;
    if (got.slot !== want.slot) report_mismatch("slot", want.slot, got.slot);
    if (got.already_bound !== want.already_bound) begin
      report_mismatch("already_bound", want.already_bound, got.already_bound);
    end
    if (got.evicted !== want.evicted) report_mismatch("evicted", want.evicted, got.evicted);
    if (got.evicted_id !== want.evicted_id) begin
      report_mismatch("evicted_id", want.evicted_id, got.evicted_id);
    end
    if (got.found !== want.found) report_mismatch("found", want.found, got.found);
    if (got.pad !== want.pad) report_mismatch("padding bits", want.pad, got.pad);
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    bind_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      burst_left    = 0;
      gap_left      = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) n_accepted++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (bind_req_q.size() > 0) begin
          req = bind_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, req.id};
          s_axis_tuser  <= req.op;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, with a stall rate redrawn from 0, 15 and 50 percent
  int unsigned stall_left;
  int unsigned stall_pct;
  int unsigned rx_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
      stall_pct     = 0;
      rx_cycles     = 0;
    end else begin
      // results first, so a request taken at this edge cannot mask a stray one
      if (m_axis_tvalid && m_axis_tready) check_result(slot_result_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) begin
        slot_results_q.push_back(allocate_slot(op_e'(s_axis_tuser), s_axis_tdata[IdW-1:0]));
      end
      rx_cycles++;
      if (rx_cycles % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 23);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no request or result moved for %0d cycles", idle_cycles);
        $display("lru_binding_slot_allocator regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_request(input op_e op, input logic [IdW-1:0] id);
    bind_req_t req;
    req.op = op;
    req.id = id;
    bind_req_q.push_back(req);
  endtask

  initial begin
    logic [IdW-1:0] id_pool[32];
    int unsigned    pool_n;
    int unsigned    total_reqs;
    int unsigned    r;
    int unsigned    n;
    logic [IdW-1:0] id;
    op_e            op;

    for (n = 0; n < NumSlots; n++) begin
      slot_owner_q[n] = '0;
      slot_stamp_q[n] = '0;
    end
    for (n = 0; n < IdRange; n++) begin
      id_bound_q[n] = 1'b0;
      id_slot_q[n]  = '0;
    end
    use_count_q = '0;
    pool_n      = 0;

    // directed: extremes, hit, unbind found and not found, id zero, fill then evict
    queue_request(OP_BIND, 12'hFFF);
    queue_request(OP_BIND, 12'h001);
    queue_request(OP_BIND, 12'hFFF);
    queue_request(OP_UNBIND, 12'h001);
    queue_request(OP_UNBIND, 12'h001);
    queue_request(OP_BIND, 12'h000);
    queue_request(OP_UNBIND, 12'h000);
    for (n = 1; n < NumSlots; n++) queue_request(OP_BIND, IdW'(n << 8));
    queue_request(OP_BIND, 12'hABC);
    queue_request(OP_UNBIND, 12'hFFF);
    queue_request(OP_BIND, 12'h555);

    // random: mostly a small id pool so hits, evictions and frees stay frequent
    for (n = 0; n < RandomReqs; n++) begin
      if (n % 150 == 0) begin
        pool_n = $urandom_range(10, 28);
        for (r = 0; r < pool_n; r++) id_pool[r] = IdW'($urandom_range(1, IdRange - 1));
      end
      r  = $urandom_range(0, 99);
      op = ($urandom_range(0, 99) < 65) ? OP_BIND : OP_UNBIND;
      if (r < 2) begin
        id = '0;
      end else if (r < 8) begin
        id = IdW'($urandom_range(1, IdRange - 1));
      end else begin
        id = id_pool[$urandom_range(0, pool_n - 1)];
      end
      queue_request(op, id);
    end
    total_reqs = bind_req_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < total_reqs) @(posedge clk_i);
    while (slot_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests checked: %0d new slots, %0d rebinds, %0d evictions",
             n_checked, n_fills, n_hits, n_evictions);
    $display("%0d slots freed, %0d unbinds of unbound ids, %0d zero-id requests ignored",
             n_freed, n_unbind_miss, n_ignored);
    if (err_cnt == 0) begin
      $display("lru_binding_slot_allocator regression: pass");
    end else begin
      $display("lru_binding_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lbsa_pkg.sv
hw/rtl/lbsa_cell.sv
hw/rtl/lru_binding_slot_allocator.sv
tb/tb_top.sv
